/* sv/rdp_pkg.sv */
// shared constants and types of the polyline break point finder
`timescale 1ns / 1ps
package rdp_pkg;
  localparam int MAX_POINTS = 64;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int CNT_W      = IDX_W + 1;
  localparam int COORD_W    = 12;
  localparam int PT_W       = 2 * COORD_W;
  localparam int SPAN_W     = 2 * IDX_W;
  localparam int THR_W      = 16;
  localparam logic [THR_W-1:0] THR_RESET = 16'd48;
  localparam int DIFF_W     = COORD_W + 1;
  localparam int PROD_W     = 2 * DIFF_W;
  localparam int CROSS_W    = 2 * COORD_W + 1;
  localparam int CC_W       = 2 * CROSS_W;
  localparam int LEN_W      = 2 * COORD_W + 1;
  localparam int RHS_W      = 2 * THR_W + LEN_W;
  localparam int LHS_W      = CC_W + 8;

  typedef enum logic [4:0] {
    B_IDLE, B_POP, B_POPW, B_LA, B_LB, B_LC, B_SCAN, B_DRAIN,
    B_T0, B_T1, B_T2, B_T3, B_PUSH1, B_PUSH2,
    B_ENEXT, B_ECUR, B_EJ, B_EJCMP, B_EPUT, B_EFLUSH
  } back_state_t;

  typedef struct packed {
    logic              valid;
    logic [CNT_W-1:0]  count;
  } edge_tok_t;
endpackage

/* sv/rdp_ram.sv */
// generic single write port ram with registered read
`timescale 1ns / 1ps
module rdp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* sv/rdp_queue.sv */
// two entry queue of edge point counts between front and back
`timescale 1ns / 1ps
module rdp_queue import rdp_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [CNT_W-1:0] push_data,
  output logic             ready,
  input  logic             pop,
  output edge_tok_t        head
);
  logic [CNT_W-1:0] ent_r [2];
  logic             wp_r, rp_r;
  logic [1:0]       fill_r;

  assign ready = (fill_r != 2'd2);
  assign head  = '{valid: (fill_r != 2'd0), count: ent_r[rp_r]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r   <= 1'b0;
      rp_r   <= 1'b0;
      fill_r <= 2'd0;
    end else begin
      if (push && ready) begin
        ent_r[wp_r] <= push_data;
        wp_r        <= ~wp_r;
      end
      if (pop && head.valid) begin
        rp_r <= ~rp_r;
      end
      fill_r <= fill_r + {1'b0, push && ready} - {1'b0, pop && head.valid};
    end
  end
endmodule

/* sv/rdp_front.sv */
// front end: loads edge points into the point store and queues the edge
`timescale 1ns / 1ps
module rdp_front import rdp_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic [COORD_W-1:0] in_point_x,
  input  logic [COORD_W-1:0] in_point_y,
  input  logic               in_last_point,
  output logic               in_stall,
  output logic               pt_we,
  output logic [IDX_W-1:0]   pt_waddr,
  output logic [PT_W-1:0]    pt_wdata,
  output logic               q_push,
  output logic [CNT_W-1:0]   q_data,
  input  logic               q_ready,
  input  logic               done
);
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             acc;
  logic             room;

  assign in_stall = busy_r || !q_ready;
  assign acc      = in_valid && !in_stall;
  assign room     = (cnt_r < CNT_W'(MAX_POINTS));
  assign pt_we    = acc && room;
  assign pt_waddr = cnt_r[IDX_W-1:0];
  assign pt_wdata = {in_point_x, in_point_y};
  assign q_push   = acc && in_last_point;
  assign q_data   = room ? cnt_r + CNT_W'(1) : cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
    end else begin
      if (q_push) begin
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end else begin
        if (pt_we) begin
          cnt_r <= cnt_r + CNT_W'(1);
        end
        if (done) begin
          busy_r <= 1'b0;
        end
      end
    end
  end
endmodule

/* sv/rdp_back.sv */
// back end: span stack splitting, then dedup and emission of kept points
`timescale 1ns / 1ps
module rdp_back import rdp_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [THR_W-1:0]   cfg_wdata,
  input  edge_tok_t          head,
  output logic               q_pop,
  output logic               done,
  output logic [IDX_W-1:0]   pt_raddr,
  input  logic [PT_W-1:0]    pt_rdata,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [COORD_W-1:0] out_break_x,
  output logic [COORD_W-1:0] out_break_y,
  output logic [IDX_W-1:0]   out_break_index,
  output logic               out_last_break
);
  back_state_t state_r, state_nxt;

  logic [THR_W-1:0]         thr_r;
  logic [CNT_W-1:0]         n_r, sp_r, ei_r, ej_r;
  logic [IDX_W-1:0]         lo_r, hi_r, i_r, bi_r;
  logic [PT_W-1:0]          a_r, cur_r, pend_r;
  logic [IDX_W-1:0]         pend_idx_r;
  logic                     pend_v_r;
  logic signed [DIFF_W-1:0] dx_r, dy_r;
  logic                     v1_r, v2_r, v3_r;
  logic [IDX_W-1:0]         idx1_r, idx2_r, idx3_r;
  logic signed [PROD_W-1:0] m1_r, m2_r, dxx_r, dyy_r;
  logic [CROSS_W-1:0]       c_r, best_r;
  logic [CC_W-1:0]          cc_r;
  logic [2*THR_W-1:0]       t2_r;
  logic [LEN_W-1:0]         len2_r;
  logic [RHS_W-1:0]         rhs_r;
  logic [MAX_POINTS-1:0]    keep_r;
  logic                     out_valid_r, out_last_r;
  logic [PT_W-1:0]          out_pt_r;
  logic [IDX_W-1:0]         out_idx_r;

  logic                     st_we;
  logic [IDX_W-1:0]         st_waddr, st_raddr;
  logic [SPAN_W-1:0]        st_wdata, st_rdata;
  logic [IDX_W-1:0]         pop_lo, pop_hi;
  logic signed [DIFF_W-1:0] px, py;
  logic signed [PROD_W:0]   diff;
  logic [PROD_W:0]          diff_abs;
  logic [LHS_W-1:0]         lhs;
  logic                     split, ofree, short_span, scan_end, out_load;

  rdp_ram #(.WIDTH(SPAN_W), .DEPTH(MAX_POINTS)) u_stack (
    .clk(clk), .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
    .raddr(st_raddr), .rdata(st_rdata)
  );

  assign pop_lo     = st_rdata[SPAN_W-1:IDX_W];
  assign pop_hi     = st_rdata[IDX_W-1:0];
  assign short_span = ({1'b0, pop_hi} < ({1'b0, pop_lo} + CNT_W'(2)));
  assign scan_end   = (i_r == hi_r - IDX_W'(1));
  assign px         = $signed({1'b0, pt_rdata[PT_W-1:COORD_W]})
                    - $signed({1'b0, a_r[PT_W-1:COORD_W]});
  assign py         = $signed({1'b0, pt_rdata[COORD_W-1:0]})
                    - $signed({1'b0, a_r[COORD_W-1:0]});
  assign diff       = {m1_r[PROD_W-1], m1_r} - {m2_r[PROD_W-1], m2_r};
  assign diff_abs   = diff[PROD_W] ? $unsigned(-diff) : $unsigned(diff);
  assign lhs        = {cc_r, 8'd0};
  assign split      = (best_r != '0) && (lhs > LHS_W'(rhs_r));
  assign ofree      = !out_valid_r || !out_stall;
  assign out_load   = ((state_r == B_EPUT) && pend_v_r && ofree)
                    || ((state_r == B_EFLUSH) && ofree);

  assign out_valid       = out_valid_r;
  assign out_break_x     = out_pt_r[PT_W-1:COORD_W];
  assign out_break_y     = out_pt_r[COORD_W-1:0];
  assign out_break_index = out_idx_r;
  assign out_last_break  = out_last_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_IDLE:   if (head.valid) state_nxt = B_POP;
      B_POP:    state_nxt = (sp_r == '0) ? B_ENEXT : B_POPW;
      B_POPW:   state_nxt = short_span ? B_POP : B_LA;
      B_LA:     state_nxt = B_LB;
      B_LB:     state_nxt = B_LC;
      B_LC:     state_nxt = (pt_rdata == a_r) ? B_POP : B_SCAN;
      B_SCAN:   if (scan_end) state_nxt = B_DRAIN;
      B_DRAIN:  if (!(v1_r || v2_r || v3_r)) state_nxt = B_T0;
      B_T0:     state_nxt = B_T1;
      B_T1:     state_nxt = B_T2;
      B_T2:     state_nxt = B_T3;
      B_T3:     state_nxt = split ? B_PUSH1 : B_POP;
      B_PUSH1:  state_nxt = B_PUSH2;
      B_PUSH2:  state_nxt = B_POP;
      B_ENEXT: begin
        priority if (ei_r == n_r) state_nxt = B_EFLUSH;
        else if (keep_r[ei_r[IDX_W-1:0]]) state_nxt = B_ECUR;
      end
      B_ECUR:   state_nxt = B_EJ;
      B_EJ: begin
        priority if (ej_r == ei_r) state_nxt = B_EPUT;
        else if (keep_r[ej_r[IDX_W-1:0]]) state_nxt = B_EJCMP;
      end
      B_EJCMP:  state_nxt = (pt_rdata == cur_r) ? B_ENEXT : B_EJ;
      B_EPUT:   if (!pend_v_r || ofree) state_nxt = B_ENEXT;
      B_EFLUSH: if (ofree) state_nxt = B_IDLE;
      default:  state_nxt = B_IDLE;
    endcase
  end

  // memory ports and handshakes
  always_comb begin
    q_pop    = 1'b0;
    done     = 1'b0;
    st_we    = 1'b0;
    st_waddr = sp_r[IDX_W-1:0];
    st_wdata = {lo_r, bi_r};
    st_raddr = sp_r[IDX_W-1:0] - IDX_W'(1);
    pt_raddr = lo_r;
    unique case (state_r)
      B_IDLE: begin
        q_pop    = head.valid;
        st_we    = head.valid;
        st_waddr = '0;
        st_wdata = {IDX_W'(0), IDX_W'(head.count - CNT_W'(1))};
      end
      B_LB:     pt_raddr = hi_r;
      B_SCAN:   pt_raddr = i_r;
      B_PUSH1: begin
        st_we    = 1'b1;
        st_wdata = {bi_r, hi_r};
      end
      B_PUSH2:  st_we = 1'b1;
      B_ENEXT:  pt_raddr = ei_r[IDX_W-1:0];
      B_EJ:     pt_raddr = ej_r[IDX_W-1:0];
      B_EFLUSH: done = ofree;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      thr_r       <= THR_RESET;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
      sp_r        <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        thr_r <= cfg_wdata;
      end

      // cross product pipeline
      v1_r   <= (state_r == B_SCAN);
      idx1_r <= i_r;
      v2_r   <= v1_r;
      idx2_r <= idx1_r;
      m1_r   <= dx_r * py;
      m2_r   <= dy_r * px;
      v3_r   <= v2_r;
      idx3_r <= idx2_r;
      c_r    <= diff_abs[CROSS_W-1:0];
      if (v3_r && (c_r > best_r)) begin
        best_r <= c_r;
        bi_r   <= idx3_r;
      end

      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        B_IDLE: if (head.valid) begin
          n_r    <= head.count;
          sp_r   <= CNT_W'(1);
          keep_r <= '0;
        end
        B_POP: if (sp_r != '0) begin
          sp_r <= sp_r - CNT_W'(1);
        end else begin
          ei_r <= '0;
        end
        B_POPW: begin
          lo_r   <= pop_lo;
          hi_r   <= pop_hi;
          keep_r <= keep_r | (MAX_POINTS'(1) << pop_lo) | (MAX_POINTS'(1) << pop_hi);
        end
        B_LB: a_r <= pt_rdata;
        B_LC: begin
          dx_r   <= $signed({1'b0, pt_rdata[PT_W-1:COORD_W]})
                  - $signed({1'b0, a_r[PT_W-1:COORD_W]});
          dy_r   <= $signed({1'b0, pt_rdata[COORD_W-1:0]})
                  - $signed({1'b0, a_r[COORD_W-1:0]});
          i_r    <= lo_r + IDX_W'(1);
          best_r <= '0;
          bi_r   <= '0;
        end
        B_SCAN: i_r <= i_r + IDX_W'(1);
        B_T0: begin
          cc_r  <= best_r * best_r;
          t2_r  <= thr_r * thr_r;
          dxx_r <= dx_r * dx_r;
          dyy_r <= dy_r * dy_r;
        end
        B_T1: len2_r <= LEN_W'($unsigned(dxx_r + dyy_r));
        B_T2: rhs_r  <= t2_r * len2_r;
        B_PUSH1, B_PUSH2: sp_r <= sp_r + CNT_W'(1);
        B_ENEXT: if (ei_r != n_r && !keep_r[ei_r[IDX_W-1:0]]) begin
          ei_r <= ei_r + CNT_W'(1);
        end
        B_ECUR: begin
          cur_r <= pt_rdata;
          ej_r  <= '0;
        end
        B_EJ: if (ej_r != ei_r && !keep_r[ej_r[IDX_W-1:0]]) begin
          ej_r <= ej_r + CNT_W'(1);
        end
        B_EJCMP: begin
          if (pt_rdata == cur_r) begin
            ei_r <= ei_r + CNT_W'(1);
          end else begin
            ej_r <= ej_r + CNT_W'(1);
          end
        end
        B_EPUT: if (!pend_v_r || ofree) begin
          if (pend_v_r) begin
            out_pt_r   <= pend_r;
            out_idx_r  <= pend_idx_r;
            out_last_r <= 1'b0;
          end
          pend_r     <= cur_r;
          pend_idx_r <= ei_r[IDX_W-1:0];
          pend_v_r   <= 1'b1;
          ei_r       <= ei_r + CNT_W'(1);
        end
        B_EFLUSH: if (ofree) begin
          out_pt_r   <= pend_r;
          out_idx_r  <= pend_idx_r;
          out_last_r <= 1'b1;
          pend_v_r   <= 1'b0;
        end
        default: ;
      endcase
    end
  end
endmodule

/* sv/polyline_break_point_finder.sv */
// top level of the polyline break point finder
// loading: one point word per cycle unless stalled; the last point word hands the edge
// to the back end, then input stalls until the last break word enters the output register
// splitting: a span without inner points or with a degenerate chord is dropped, otherwise
// its inner points are scanned and it splits at the farthest one beyond the threshold
// emission: duplicate check scans earlier kept points
// synchronous active-low reset: threshold 48, queue empty, no output word pending
`timescale 1ns / 1ps
module polyline_break_point_finder import rdp_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [COORD_W-1:0] in_point_x,
  input  logic [COORD_W-1:0] in_point_y,
  input  logic               in_last_point,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [COORD_W-1:0] out_break_x,
  output logic [COORD_W-1:0] out_break_y,
  output logic [IDX_W-1:0]   out_break_index,
  output logic               out_last_break,
  input  logic               cfg_we,
  input  logic [THR_W-1:0]   cfg_wdata
);
  logic             pt_we;
  logic [IDX_W-1:0] pt_waddr, pt_raddr;
  logic [PT_W-1:0]  pt_wdata, pt_rdata;
  logic             q_push, q_ready, q_pop, done;
  logic [CNT_W-1:0] q_data;
  edge_tok_t        head;

  rdp_front u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_point_x(in_point_x), .in_point_y(in_point_y),
    .in_last_point(in_last_point), .in_stall(in_stall),
    .pt_we(pt_we), .pt_waddr(pt_waddr), .pt_wdata(pt_wdata),
    .q_push(q_push), .q_data(q_data), .q_ready(q_ready), .done(done)
  );

  rdp_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push(q_push), .push_data(q_data),
    .ready(q_ready), .pop(q_pop), .head(head)
  );

  rdp_ram #(.WIDTH(PT_W), .DEPTH(MAX_POINTS)) u_points (
    .clk(clk), .we(pt_we), .waddr(pt_waddr), .wdata(pt_wdata),
    .raddr(pt_raddr), .rdata(pt_rdata)
  );

  rdp_back u_back (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .head(head), .q_pop(q_pop), .done(done),
    .pt_raddr(pt_raddr), .pt_rdata(pt_rdata),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_break_x(out_break_x), .out_break_y(out_break_y),
    .out_break_index(out_break_index), .out_last_break(out_last_break)
  );
endmodule

/* sv/rdp_checker.sv */
// port level checks of the polyline break point finder and their binding
`timescale 1ns / 1ps
module rdp_checker import rdp_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               in_last_point,
  input logic               out_valid,
  input logic               out_stall,
  input logic [COORD_W-1:0] out_break_x,
  input logic [COORD_W-1:0] out_break_y,
  input logic [IDX_W-1:0]   out_break_index,
  input logic               out_last_break
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("output word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_break_x) && $stable(out_break_y)
      && $stable(out_break_index) && $stable(out_last_break))
    else $error("stalled output word changed");

  a_edge_lock: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_last_point |=> in_stall)
    else $error("input taken after last point before edge finished");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output word present after reset");
endmodule

bind polyline_break_point_finder rdp_checker u_rdp_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .in_last_point(in_last_point), .out_valid(out_valid), .out_stall(out_stall),
  .out_break_x(out_break_x), .out_break_y(out_break_y),
  .out_break_index(out_break_index), .out_last_break(out_last_break)
);
